// ===== sv/cubic_bezier_easing_macros.svh =====
// ----------------------------------------------------------------------------
// Cubic bezier easing assertion macros
// Shared property forms for the easing block checks.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASING_MACROS_SVH
`define CUBIC_BEZIER_EASING_MACROS_SVH

// same-cycle implication
`define CBE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Cubic bezier easing package
// Shared types, constants and saturating fixed-point helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cbe_pkg;

    localparam int MAX_ITERATIONS_DEF = 10;
    localparam int FRAC_BITS_DEF      = 28;
    localparam int QUEUE_DEPTH        = 2;

    typedef logic signed [63:0] fix_t;

    localparam fix_t SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam fix_t SAT_MIN = -64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam fix_t OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam fix_t OUT_MIN = -64'sh0000_0000_8000_0000;

    typedef enum logic [1:0] {
        REG_X0,
        REG_Y0,
        REG_X1,
        REG_Y1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
    } ctrl_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic               bypass;
    } job_t;

    typedef struct packed {
        logic signed [31:0] eased_value;
        logic               bypassed;
    } result_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_COEF1,
        B_COEF2,
        B_COEF3,
        B_COEF4,
        B_LOAD,
        B_MUL,
        B_RND,
        B_ACC,
        B_DIV,
        B_DIVEND,
        B_NEWR,
        B_CHECK,
        B_DONE
    } back_state_t;

    typedef enum logic [3:0] {
        OP_N1,
        OP_N2,
        OP_N3,
        OP_D1,
        OP_D2,
        OP_E,
        OP_F,
        OP_G,
        OP_H,
        OP_K,
        OP_Y
    } mac_op_t;

    function automatic fix_t sadd(fix_t a, fix_t b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > SUM_MAX)
            return SAT_MAX;
        if (s < SUM_MIN)
            return SAT_MIN;
        return s[63:0];
    endfunction

    function automatic fix_t ssub(fix_t a, fix_t b);
        return sadd(a, -b);
    endfunction

    function automatic fix_t times3(fix_t a);
        return sadd(sadd(a, a), a);
    endfunction

    function automatic logic [63:0] mag(fix_t a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function automatic fix_t from_mag(logic [63:0] m, logic neg, logic over);
        if (over || m[63])
            return neg ? SAT_MIN : SAT_MAX;
        return neg ? -fix_t'(m) : fix_t'(m);
    endfunction

    function automatic fix_t eps_fixed(int fb);
        logic [63:0] m;
        m = 64'd13743895;
        if (fb >= 37)
            return fix_t'(m << (fb - 37));
        return fix_t'((m + (64'd1 << (36 - fb))) >> (37 - fb));
    endfunction

endpackage
`default_nettype wire

// ===== sv/cbe_fifo.sv =====
// ----------------------------------------------------------------------------
// Cubic bezier easing word queue
// Small first-word fall-through queue between block stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cbe_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = cbe_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] din,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      dout,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule
`default_nettype wire

// ===== sv/cbe_front.sv =====
// ----------------------------------------------------------------------------
// Cubic bezier easing front end
// Takes positions and marks those that pass straight through.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cbe_front #(
    parameter int FRAC_BITS = cbe_pkg::FRAC_BITS_DEF
) (
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] position,
    input  wire cbe_pkg::ctrl_t     ctrl,
    input  wire logic               q_full,
    output logic                    q_push,
    output cbe_pkg::job_t           q_data
);

    localparam cbe_pkg::fix_t ONE = cbe_pkg::fix_t'(64'd1 << FRAC_BITS);

    cbe_pkg::fix_t x0s;
    cbe_pkg::fix_t x1s;
    logic          x_in_unit;
    logic          linear;

    assign x0s       = cbe_pkg::fix_t'(ctrl.x0);
    assign x1s       = cbe_pkg::fix_t'(ctrl.x1);
    assign x_in_unit = (x0s >= 0) && (x0s <= ONE) && (x1s >= 0) && (x1s <= ONE);
    assign linear    = (ctrl.x0 == ctrl.y0) && (ctrl.x1 == ctrl.y1);

    assign full            = q_full;
    assign q_push          = push && !q_full;
    assign q_data.position = position;
    assign q_data.bypass   = !x_in_unit || linear;

endmodule
`default_nettype wire

// ===== sv/cbe_back.sv =====
// ----------------------------------------------------------------------------
// Cubic bezier easing back end
// Newton solve of x(r)=t and de Casteljau y(r) on a shared multiply-add
// unit and a radix-2 restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cbe_back #(
    parameter int MAX_ITERATIONS = cbe_pkg::MAX_ITERATIONS_DEF,
    parameter int FRAC_BITS      = cbe_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cbe_pkg::ctrl_t    ctrl,
    input  wire cbe_pkg::job_t     job,
    input  wire logic              job_empty,
    output logic                   job_pop,
    output cbe_pkg::result_t       res,
    input  wire logic              res_full,
    output logic                   res_push
);

    localparam cbe_pkg::fix_t ONE  = cbe_pkg::fix_t'(64'd1 << FRAC_BITS);
    localparam cbe_pkg::fix_t EPS  = cbe_pkg::eps_fixed(FRAC_BITS);
    localparam logic [127:0]  HALF = 128'd1 << (FRAC_BITS - 1);
    localparam int IT_W  = $clog2(MAX_ITERATIONS + 1);
    localparam int DIV_STEPS = 128;
    localparam int DCW   = $clog2(DIV_STEPS);

    cbe_pkg::back_state_t state_reg, state_next;
    cbe_pkg::mac_op_t     op_reg;

    cbe_pkg::fix_t pos_reg, r_reg, rnext_reg, q_reg;
    cbe_pkg::fix_t b_reg, c_reg, d_reg;
    cbe_pkg::fix_t c3_reg, c2_reg, c1_reg, c0_reg, c3x3_reg, c2x2_reg;
    cbe_pkg::fix_t t_reg, n_reg, e_reg, f_reg, g_reg;
    cbe_pkg::fix_t addend_reg, p_reg;
    logic [63:0]   ma_reg, mb_reg;
    logic          mneg_reg;
    logic [127:0]  prod_reg;
    logic [1:0]    part_reg;
    logic [127:0]  dvd_reg;
    logic [63:0]   dsor_reg, rem_reg, quo_reg;
    logic          dover_reg, dneg_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [IT_W-1:0] it_reg;
    cbe_pkg::result_t res_reg;

    cbe_pkg::fix_t ys0, ys1;
    cbe_pkg::fix_t op_a, op_c, acc_v, newr, step;
    logic [127:0]  partial, rounded, shifted;
    logic [63:0]   rem_sh;
    logic          rem_carry, rem_ge;
    logic          stop;

    assign ys0 = cbe_pkg::fix_t'(ctrl.y0);
    assign ys1 = cbe_pkg::fix_t'(ctrl.y1);

    // operand select for the multiply-add: result = A * r + C
    always_comb
    begin
        op_a = c3_reg;
        op_c = c2_reg;
        unique case (op_reg)
            cbe_pkg::OP_N1: begin op_a = c3_reg; op_c = c2_reg; end
            cbe_pkg::OP_N2: begin op_a = t_reg; op_c = c1_reg; end
            cbe_pkg::OP_N3: begin op_a = t_reg; op_c = c0_reg; end
            cbe_pkg::OP_D1: begin op_a = c3x3_reg; op_c = c2x2_reg; end
            cbe_pkg::OP_D2: begin op_a = t_reg; op_c = c1_reg; end
            cbe_pkg::OP_E:  begin op_a = ys0; op_c = '0; end
            cbe_pkg::OP_F:  begin op_a = cbe_pkg::ssub(ys1, ys0); op_c = ys0; end
            cbe_pkg::OP_G:  begin op_a = cbe_pkg::ssub(ONE, ys1); op_c = ys1; end
            cbe_pkg::OP_H:  begin op_a = cbe_pkg::ssub(f_reg, e_reg); op_c = e_reg; end
            cbe_pkg::OP_K:  begin op_a = cbe_pkg::ssub(g_reg, f_reg); op_c = f_reg; end
            cbe_pkg::OP_Y:  begin op_a = cbe_pkg::ssub(f_reg, e_reg); op_c = e_reg; end
            default:        begin op_a = c3_reg; op_c = c2_reg; end
        endcase
    end

    // one 32x32 partial product per cycle
    always_comb
    begin
        unique case (part_reg)
            2'd0: partial = 128'(ma_reg[31:0] * mb_reg[31:0]);
            2'd1: partial = 128'(ma_reg[31:0] * mb_reg[63:32]) << 32;
            2'd2: partial = 128'(ma_reg[63:32] * mb_reg[31:0]) << 32;
            2'd3: partial = 128'(ma_reg[63:32] * mb_reg[63:32]) << 64;
            default: partial = '0;
        endcase
    end

    assign rounded   = prod_reg + HALF;
    assign shifted   = rounded >> FRAC_BITS;
    assign acc_v     = cbe_pkg::sadd(p_reg, addend_reg);
    assign rem_carry = rem_reg[63];
    assign rem_sh    = {rem_reg[62:0], dvd_reg[127]};
    assign rem_ge    = rem_carry || (rem_sh >= dsor_reg);
    assign newr      = cbe_pkg::ssub(r_reg, q_reg);
    assign step      = cbe_pkg::ssub(rnext_reg, r_reg);
    assign stop      = ((step <= EPS) && (step >= -EPS))
                    || ((it_reg + 1'b1) == IT_W'(MAX_ITERATIONS));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbe_pkg::B_IDLE:
                if (!job_empty)
                    state_next = job.bypass ? cbe_pkg::B_DONE : cbe_pkg::B_COEF1;
            cbe_pkg::B_COEF1:  state_next = cbe_pkg::B_COEF2;
            cbe_pkg::B_COEF2:  state_next = cbe_pkg::B_COEF3;
            cbe_pkg::B_COEF3:  state_next = cbe_pkg::B_COEF4;
            cbe_pkg::B_COEF4:  state_next = cbe_pkg::B_LOAD;
            cbe_pkg::B_LOAD:   state_next = cbe_pkg::B_MUL;
            cbe_pkg::B_MUL:
                if (part_reg == 2'd3)
                    state_next = cbe_pkg::B_RND;
            cbe_pkg::B_RND:    state_next = cbe_pkg::B_ACC;
            cbe_pkg::B_ACC:
            begin
                priority if (op_reg == cbe_pkg::OP_D2)
                    state_next = (acc_v == 0) ? cbe_pkg::B_NEWR : cbe_pkg::B_DIV;
                else if (op_reg == cbe_pkg::OP_Y)
                    state_next = cbe_pkg::B_DONE;
                else
                    state_next = cbe_pkg::B_LOAD;
            end
            cbe_pkg::B_DIV:
                if (dcnt_reg == DCW'(DIV_STEPS - 1))
                    state_next = cbe_pkg::B_DIVEND;
            cbe_pkg::B_DIVEND: state_next = cbe_pkg::B_NEWR;
            cbe_pkg::B_NEWR:   state_next = cbe_pkg::B_CHECK;
            cbe_pkg::B_CHECK:  state_next = cbe_pkg::B_LOAD;
            cbe_pkg::B_DONE:
                if (!res_full)
                    state_next = cbe_pkg::B_IDLE;
            default:           state_next = cbe_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop  = (state_reg == cbe_pkg::B_IDLE) && !job_empty;
        res_push = (state_reg == cbe_pkg::B_DONE);
        res      = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cbe_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            cbe_pkg::B_IDLE:
            begin
                pos_reg <= cbe_pkg::fix_t'(job.position);
                res_reg.eased_value <= job.position;
                res_reg.bypassed    <= 1'b1;
            end
            cbe_pkg::B_COEF1:
            begin
                b_reg  <= cbe_pkg::ssub(cbe_pkg::fix_t'(ctrl.x1), cbe_pkg::fix_t'(ctrl.x0));
                c_reg  <= cbe_pkg::ssub(ONE, cbe_pkg::fix_t'(ctrl.x1));
                c1_reg <= cbe_pkg::times3(cbe_pkg::fix_t'(ctrl.x0));
            end
            cbe_pkg::B_COEF2:
            begin
                d_reg  <= cbe_pkg::ssub(b_reg, cbe_pkg::fix_t'(ctrl.x0));
                r_reg  <= pos_reg;
                c0_reg <= -pos_reg;
                it_reg <= '0;
            end
            cbe_pkg::B_COEF3:
            begin
                c3_reg <= cbe_pkg::ssub(cbe_pkg::ssub(c_reg, b_reg), d_reg);
                c2_reg <= cbe_pkg::times3(d_reg);
            end
            cbe_pkg::B_COEF4:
            begin
                c3x3_reg <= cbe_pkg::times3(c3_reg);
                c2x2_reg <= cbe_pkg::sadd(c2_reg, c2_reg);
                op_reg   <= cbe_pkg::OP_N1;
            end
            cbe_pkg::B_LOAD:
            begin
                ma_reg     <= cbe_pkg::mag(op_a);
                mb_reg     <= cbe_pkg::mag(r_reg);
                mneg_reg   <= (op_a < 0) != (r_reg < 0);
                addend_reg <= op_c;
                prod_reg   <= '0;
                part_reg   <= '0;
            end
            cbe_pkg::B_MUL:
            begin
                prod_reg <= prod_reg + partial;
                part_reg <= part_reg + 1'b1;
            end
            cbe_pkg::B_RND:
                p_reg <= cbe_pkg::from_mag(shifted[63:0], mneg_reg, |shifted[127:64]);
            cbe_pkg::B_ACC:
            begin
                unique case (op_reg)
                    cbe_pkg::OP_N1: begin t_reg <= acc_v; op_reg <= cbe_pkg::OP_N2; end
                    cbe_pkg::OP_N2: begin t_reg <= acc_v; op_reg <= cbe_pkg::OP_N3; end
                    cbe_pkg::OP_N3: begin n_reg <= acc_v; op_reg <= cbe_pkg::OP_D1; end
                    cbe_pkg::OP_D1: begin t_reg <= acc_v; op_reg <= cbe_pkg::OP_D2; end
                    cbe_pkg::OP_D2:
                    begin
                        // zero derivative gives a zero Newton term
                        q_reg     <= '0;
                        dvd_reg   <= {64'd0, cbe_pkg::mag(n_reg)} << FRAC_BITS;
                        dsor_reg  <= cbe_pkg::mag(acc_v);
                        dneg_reg  <= (n_reg < 0) != (acc_v < 0);
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        dover_reg <= 1'b0;
                        dcnt_reg  <= '0;
                    end
                    cbe_pkg::OP_E: begin e_reg <= acc_v; op_reg <= cbe_pkg::OP_F; end
                    cbe_pkg::OP_F: begin f_reg <= acc_v; op_reg <= cbe_pkg::OP_G; end
                    cbe_pkg::OP_G: begin g_reg <= acc_v; op_reg <= cbe_pkg::OP_H; end
                    cbe_pkg::OP_H: begin e_reg <= acc_v; op_reg <= cbe_pkg::OP_K; end
                    cbe_pkg::OP_K: begin f_reg <= acc_v; op_reg <= cbe_pkg::OP_Y; end
                    cbe_pkg::OP_Y:
                    begin
                        res_reg.bypassed <= 1'b0;
                        priority if (acc_v > cbe_pkg::OUT_MAX)
                            res_reg.eased_value <= 32'sh7FFF_FFFF;
                        else if (acc_v < cbe_pkg::OUT_MIN)
                            res_reg.eased_value <= -32'sh8000_0000;
                        else
                            res_reg.eased_value <= acc_v[31:0];
                    end
                    default: op_reg <= cbe_pkg::OP_N1;
                endcase
            end
            cbe_pkg::B_DIV:
            begin
                dvd_reg   <= dvd_reg << 1;
                rem_reg   <= rem_ge ? rem_sh - dsor_reg : rem_sh;
                dover_reg <= dover_reg | quo_reg[63];
                quo_reg   <= {quo_reg[62:0], rem_ge};
                dcnt_reg  <= dcnt_reg + 1'b1;
            end
            cbe_pkg::B_DIVEND:
                q_reg <= cbe_pkg::from_mag(quo_reg, dneg_reg, dover_reg);
            cbe_pkg::B_NEWR:
            begin
                // clamp the new estimate to the unit interval
                priority if (newr > ONE)
                    rnext_reg <= ONE;
                else if (newr < 0)
                    rnext_reg <= '0;
                else
                    rnext_reg <= newr;
            end
            cbe_pkg::B_CHECK:
            begin
                r_reg  <= rnext_reg;
                it_reg <= it_reg + 1'b1;
                op_reg <= stop ? cbe_pkg::OP_E : cbe_pkg::OP_N1;
            end
            cbe_pkg::B_DONE:
                ;
            default:
                ;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/cubic_bezier_easing.sv =====
// A passed-through position goes through the job queue and the back end, which hands it
// straight to the result queue; a solved one runs coefficient setup, Newton steps (five
// multiply-adds, a one-bit-per-cycle divide that is skipped when the derivative is zero,
// and the estimate update), curve evaluation and the output state. The shared divider and
// multiply-add unit handle one word at a time: the back end takes no new word until the
// last has gone into the result queue. Reset: control points (0,0) and (1.0,1.0); queues empty.
// ----------------------------------------------------------------------------
// Cubic bezier easing top level
// Configuration registers, input and result queues, front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_bezier_easing_macros.svh"
module cubic_bezier_easing #(
    parameter int MAX_ITERATIONS = cbe_pkg::MAX_ITERATIONS_DEF,
    parameter int FRAC_BITS      = cbe_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] position,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      eased_value,
    output logic                    bypassed,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam int JOB_W = $bits(cbe_pkg::job_t);
    localparam int RES_W = $bits(cbe_pkg::result_t);

    cbe_pkg::ctrl_t   ctrl_reg;
    cbe_pkg::job_t    front_job, job;
    cbe_pkg::result_t back_res, out_res;
    logic             job_push, job_full, job_empty, job_pop;
    logic             res_push, res_full;
    logic [JOB_W-1:0] job_word;
    logic [RES_W-1:0] res_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.x0 <= '0;
            ctrl_reg.y0 <= '0;
            ctrl_reg.x1 <= 32'sh1000_0000;
            ctrl_reg.y1 <= 32'sh1000_0000;
        end
        else if (cfg_write)
        begin
            unique case (cbe_pkg::cfg_reg_t'(cfg_index))
                cbe_pkg::REG_X0: ctrl_reg.x0 <= cfg_data;
                cbe_pkg::REG_Y0: ctrl_reg.y0 <= cfg_data;
                cbe_pkg::REG_X1: ctrl_reg.x1 <= cfg_data;
                cbe_pkg::REG_Y1: ctrl_reg.y1 <= cfg_data;
                default:         ctrl_reg    <= ctrl_reg;
            endcase
        end
    end

    cbe_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .push     (push),
        .full     (full),
        .position (position),
        .ctrl     (ctrl_reg),
        .q_full   (job_full),
        .q_push   (job_push),
        .q_data   (front_job)
    );

    cbe_fifo #(.W(JOB_W), .DEPTH(cbe_pkg::QUEUE_DEPTH)) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (front_job),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_word),
        .empty (job_empty)
    );

    assign job = cbe_pkg::job_t'(job_word);

    cbe_back #(.MAX_ITERATIONS(MAX_ITERATIONS), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl_reg),
        .job       (job),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .res       (back_res),
        .res_full  (res_full),
        .res_push  (res_push)
    );

    cbe_fifo #(.W(RES_W), .DEPTH(cbe_pkg::QUEUE_DEPTH)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (back_res),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_word),
        .empty (empty)
    );

    assign out_res     = cbe_pkg::result_t'(res_word);
    assign eased_value = out_res.eased_value;
    assign bypassed    = out_res.bypassed;

    `CBE_ASSERT_NOW(a_job_pop_data, job_pop, !job_empty, "back end popped an empty queue")
    `CBE_ASSERT_NEXT(a_res_lands, res_push && !res_full && !pop, !empty, "result word lost")
    `CBE_ASSERT_NOW(a_res_source, $fell(empty), $past(res_push), "result from nowhere")

endmodule
`default_nettype wire
